@@ hw/rtl/lts_pkg.sv @@
package lts_pkg;

  localparam int LINES_DEFAULT = 16;
  localparam int TAG_W         = 32;
  localparam int STAMP_W       = 32;
  localparam int SIZE_W        = 20;
  localparam int LINE_W        = 4;

  localparam logic [SIZE_W-1:0] SIZE_LIMIT_RESET = 20'd102400;

  localparam logic KIND_LOOKUP = 1'b0;
  localparam logic KIND_INSERT = 1'b1;

  // outcome of one pass over the lines
  typedef struct packed {
    logic done;
    logic found;
    logic evict;
  } scan_res_t;

endpackage

@@ hw/rtl/lts_ram.sv @@
module lts_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/lts_scan.sv @@
module lts_scan #(
  parameter int LINES = lts_pkg::LINES_DEFAULT
) (
  input  logic                         clk,
  input  logic                         chk,
  input  logic [$clog2(LINES)-1:0]     chk_idx,
  input  logic                         line_vld,
  input  logic [lts_pkg::TAG_W-1:0]    rd_tag,
  input  logic [lts_pkg::STAMP_W-1:0]  rd_stamp,
  input  logic                         kind,
  input  logic [lts_pkg::TAG_W-1:0]    tag,
  output lts_pkg::scan_res_t           res,
  output logic [$clog2(LINES)-1:0]     res_idx
);
  import lts_pkg::*;

  localparam int IDX_W = $clog2(LINES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LINES - 1);

  logic [IDX_W-1:0]   best_idx, best_idx_next;
  logic [STAMP_W-1:0] best_stamp, best_stamp_next;
  logic               take;

  always_comb begin
    res             = '0;
    res_idx         = chk_idx;
    take            = (chk_idx == '0) || (rd_stamp < best_stamp);
    best_idx_next   = best_idx;
    best_stamp_next = best_stamp;
    if (chk) begin
      if (kind == KIND_LOOKUP) begin
        if (line_vld && rd_tag == tag) begin
          res.done  = 1'b1;
          res.found = 1'b1;
        end else if (chk_idx == LAST_IDX) begin
          res.done = 1'b1;
        end
      end else begin
        if (!line_vld) begin
          // lowest free line wins outright
          res.done  = 1'b1;
          res.found = 1'b1;
        end else begin
          if (take) begin
            best_idx_next   = chk_idx;
            best_stamp_next = rd_stamp;
          end
          if (chk_idx == LAST_IDX) begin
            res.done  = 1'b1;
            res.found = 1'b1;
            res.evict = 1'b1;
            res_idx   = best_idx_next;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    best_idx   <= best_idx_next;
    best_stamp <= best_stamp_next;
  end

endmodule

@@ hw/rtl/lru_tag_store.sv @@
// lru_tag_store: fully associative tag store with timestamp replacement.
// Input channel (in_valid/in_ready) carries kind, tag and obj_size. A
// lookup (kind 0) searches the valid lines from line 0 for the tag; on a hit
// the line gets a fresh stamp. An insert (kind 1) larger than size_limit is
// dropped; otherwise it takes the lowest free line, or the first line with
// the smallest stamp, and writes the tag and a fresh stamp.
// Output channel (out_valid/out_ready) returns one item per request: hit,
// line, placed, evicted and dropped.
// Tags and stamps live in one RAM with a registered read; the search reads
// one line per cycle over a full pass, stopping early when a hit or free
// line turns up; a dropped insert skips the search. One request is in flight
// at a time. The result sits in an output register; the next item is
// accepted while it waits, and a stalled receiver holds the block once that
// second item is done. The user must write size_limit only while idle, via
// size_limit_we/size_limit_data; the block does not enforce this. Reset clears
// the valid bits, the stamp counter and size_limit (to 102400); no clearing
// pass is needed, the RAM contents are only used for valid lines.
module lru_tag_store #(
  parameter int LINES = lts_pkg::LINES_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        size_limit_we,
  input  logic [lts_pkg::SIZE_W-1:0]  size_limit_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        kind,
  input  logic [lts_pkg::TAG_W-1:0]   tag,
  input  logic [lts_pkg::SIZE_W-1:0]  obj_size,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        hit,
  output logic [lts_pkg::LINE_W-1:0]  line,
  output logic                        placed,
  output logic                        evicted,
  output logic                        dropped
);
  import lts_pkg::*;

  localparam int IDX_W = $clog2(LINES);
  localparam int RAM_W = TAG_W + STAMP_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LINES - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_WRITE = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]         state;
  logic [SIZE_W-1:0]  size_limit;
  logic [STAMP_W-1:0] stamp_counter;
  logic [LINES-1:0]   line_valid;

  logic               kind_q;
  logic [TAG_W-1:0]   tag_q;
  logic               found_q, evict_q, drop_q;
  logic [IDX_W-1:0]   sel_idx;

  logic               iss_on, chk_vld;
  logic [IDX_W-1:0]   rd_addr, chk_idx;

  logic               ram_we;
  logic [RAM_W-1:0]   ram_wdata, ram_rdata;
  logic [STAMP_W-1:0] stamp_next;

  scan_res_t          res;
  logic [IDX_W-1:0]   res_idx;
  logic               load_out;
  logic [IDX_W+LINE_W-1:0] idx_ext;

  assign in_ready   = (state == ST_IDLE);
  assign stamp_next = stamp_counter + STAMP_W'(1);
  assign ram_we     = (state == ST_WRITE);
  assign ram_wdata  = {tag_q, stamp_next};
  assign load_out   = (state == ST_DONE) && (!out_valid || out_ready);
  assign idx_ext    = {{LINE_W{1'b0}}, sel_idx};

  lts_ram #(
    .WIDTH (RAM_W),
    .DEPTH (LINES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (sel_idx),
    .wdata (ram_wdata),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  lts_scan #(
    .LINES (LINES)
  ) u_scan (
    .clk      (clk),
    .chk      (chk_vld && state == ST_SCAN),
    .chk_idx  (chk_idx),
    .line_vld (line_valid[chk_idx]),
    .rd_tag   (ram_rdata[RAM_W-1:STAMP_W]),
    .rd_stamp (ram_rdata[STAMP_W-1:0]),
    .kind     (kind_q),
    .tag      (tag_q),
    .res      (res),
    .res_idx  (res_idx)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      size_limit    <= SIZE_LIMIT_RESET;
      stamp_counter <= '0;
      line_valid    <= '0;
      iss_on        <= 1'b0;
      chk_vld       <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (size_limit_we) begin
        size_limit <= size_limit_data;
      end
      case (state)
        ST_IDLE: begin
          chk_vld <= 1'b0;
          if (in_valid) begin
            kind_q  <= kind;
            tag_q   <= tag;
            found_q <= 1'b0;
            evict_q <= 1'b0;
            if (kind == KIND_INSERT && obj_size > size_limit) begin
              drop_q <= 1'b1;
              state  <= ST_DONE;
            end else begin
              drop_q  <= 1'b0;
              rd_addr <= '0;
              iss_on  <= 1'b1;
              state   <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          // one read issued per cycle, checked when its data returns
          chk_idx <= rd_addr;
          if (iss_on) begin
            rd_addr <= rd_addr + IDX_W'(1);
          end
          if (res.done) begin
            found_q <= res.found;
            evict_q <= res.evict;
            sel_idx <= res_idx;
            iss_on  <= 1'b0;
            chk_vld <= 1'b0;
            state   <= res.found ? ST_WRITE : ST_DONE;
          end else begin
            chk_vld <= iss_on;
            if (iss_on && rd_addr == LAST_IDX) begin
              iss_on <= 1'b0;
            end
          end
        end
        ST_WRITE: begin
          stamp_counter <= stamp_next;
          if (kind_q == KIND_INSERT) begin
            line_valid[sel_idx] <= 1'b1;
          end
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (load_out) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      hit     <= found_q && kind_q == KIND_LOOKUP;
      placed  <= found_q && kind_q == KIND_INSERT;
      evicted <= evict_q;
      dropped <= drop_q;
      line    <= found_q ? idx_ext[LINE_W-1:0] : '0;
    end
  end

endmodule

@@ hw/rtl/lts_checker.sv @@
module lts_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        hit,
  input logic [lts_pkg::LINE_W-1:0]  line,
  input logic                        placed,
  input logic                        evicted,
  input logic                        dropped
);
  import lts_pkg::*;

  // a stalled result keeps its fields
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable({hit, line, placed, evicted, dropped}))
    else $error("result changed while stalled");

  a_one_outcome: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0({hit, placed, dropped}))
    else $error("more than one outcome flagged");

  a_evict_placed: assert property (@(posedge clk) disable iff (rst)
    out_valid && evicted |-> placed)
    else $error("eviction without placement");

  a_line_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit && !placed |-> line == '0)
    else $error("line set on miss or drop");

  // one request in flight
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a second item while busy");

endmodule

bind lru_tag_store lts_checker u_lts_checker (.*);
